// ===== rtl/core/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement block: the command
// and status bundles between controller and datapath, and fixed field widths.
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int STAMP_W   = 32;
	localparam int FAULT_W   = 32;
	localparam int CFG_W     = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

	typedef struct packed {
		logic load;    // latch request, restart scan
		logic read;    // read frame at scan address, advance
		logic commit;  // update frame table, load result
	} lru_cmd_t;

	typedef struct packed {
		logic scan_last; // scan address is the last active frame
	} lru_status_t;

endpackage

// ===== rtl/core/lru_ctrl.sv =====
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer for one request: load, scan the active frames one per cycle,
// let the last read settle, then commit the replacement decision.
// ----------------------------------------------------------------------------
module lru_ctrl
	import lru_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  lru_status_t status,
	output lru_cmd_t    cmd,
	output logic        busy
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.read   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.read = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/lru_dpath.sv =====
// ----------------------------------------------------------------------------
// lru_dpath
// Frame table memory, scan address counter, running hit / empty / oldest
// trackers, stamp and fault counters, and the result registers.
// ----------------------------------------------------------------------------
module lru_dpath
	import lru_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lru_cmd_t                           cmd,
	output lru_status_t                        status,
	input  logic [PAGE_BITS-1:0]               page_number,
	input  logic                               num_frames_we,
	input  logic [CFG_W-1:0]                   num_frames,
	output logic                               done,
	output logic                               hit,
	output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] slot,
	output logic [PAGE_BITS-1:0]               evicted_page,
	output logic [FAULT_W-1:0]                 fault_total
);

	localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

	// frame table
	logic [PAGE_BITS-1:0] page_mem  [MAX_FRAMES];
	logic [STAMP_W-1:0]   stamp_mem [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;

	logic [CFG_W-1:0]     num_frames_q;
	logic [CNT_W-1:0]     active_cnt;
	logic [PAGE_BITS-1:0] page_q;
	logic [SLOT_W-1:0]    addr_q;

	logic                 rd_en_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;
	logic [PAGE_BITS-1:0] rd_page_s1;
	logic [STAMP_W-1:0]   rd_stamp_s1;
	logic                 rd_vld_s1;

	logic [PAGE_BITS-1:0] cur_page;
	logic [STAMP_W-1:0]   cur_stamp;
	logic                 first_entry;

	logic                 hit_f_q;
	logic [SLOT_W-1:0]    hit_idx_q;
	logic                 emp_f_q;
	logic [SLOT_W-1:0]    emp_idx_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic [SLOT_W-1:0]    best_idx_q;
	logic [PAGE_BITS-1:0] best_page_q;

	logic [STAMP_W-1:0]   next_stamp_q;
	logic [FAULT_W-1:0]   fault_count_q;

	logic                 wr_en;
	logic [SLOT_W-1:0]    miss_idx;
	logic [SLOT_W-1:0]    wr_idx;

	logic                 done_q;
	logic                 hit_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [PAGE_BITS-1:0] evicted_q;

	// clamp the frame count to 1..MAX_FRAMES
	always_comb begin
		priority if (num_frames_q == '0) begin
			active_cnt = CNT_W'(1);
		end else if (32'(num_frames_q) > MAX_FRAMES) begin
			active_cnt = CNT_W'(MAX_FRAMES);
		end else begin
			active_cnt = CNT_W'(num_frames_q);
		end
	end

	assign status.scan_last = (CNT_W'(addr_q) == (active_cnt - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= CFG_RESET;
		end else if (num_frames_we) begin
			num_frames_q <= num_frames;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.read;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.read) begin
				addr_q <= addr_q + SLOT_W'(1);
			end
		end
	end

	// registered memory read
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_page_s1  <= page_mem[addr_q];
			rd_stamp_s1 <= stamp_mem[addr_q];
			rd_vld_s1   <= valid_q[addr_q];
			rd_idx_s1   <= addr_q;
		end
	end

	// an entry never written reads as empty with stamp zero
	assign cur_page    = rd_vld_s1 ? rd_page_s1 : '0;
	assign cur_stamp   = rd_vld_s1 ? rd_stamp_s1 : '0;
	assign first_entry = (rd_idx_s1 == '0);

	always_ff @(posedge clk) begin
		if (rd_en_s1) begin
			if (first_entry) begin
				hit_f_q      <= (cur_page == page_q);
				hit_idx_q    <= rd_idx_s1;
				emp_f_q      <= (cur_page == '0);
				emp_idx_q    <= rd_idx_s1;
				best_stamp_q <= cur_stamp;
				best_idx_q   <= rd_idx_s1;
				best_page_q  <= cur_page;
			end else begin
				if (!hit_f_q && (cur_page == page_q)) begin
					hit_f_q   <= 1'b1;
					hit_idx_q <= rd_idx_s1;
				end
				if (!emp_f_q && (cur_page == '0)) begin
					emp_f_q   <= 1'b1;
					emp_idx_q <= rd_idx_s1;
				end
				// strict compare keeps the lowest index on ties
				if (cur_stamp < best_stamp_q) begin
					best_stamp_q <= cur_stamp;
					best_idx_q   <= rd_idx_s1;
					best_page_q  <= cur_page;
				end
			end
		end
	end

	assign miss_idx = emp_f_q ? emp_idx_q : best_idx_q;
	assign wr_idx   = hit_f_q ? hit_idx_q : miss_idx;
	assign wr_en    = cmd.commit && (page_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_mem[wr_idx]  <= page_q;
			stamp_mem[wr_idx] <= next_stamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			next_stamp_q  <= '0;
			fault_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
				if (next_stamp_q != STAMP_MAX) begin
					next_stamp_q <= next_stamp_q + STAMP_W'(1);
				end
				if (!hit_f_q && (fault_count_q != FAULT_MAX)) begin
					fault_count_q <= fault_count_q + FAULT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (page_q == '0) begin
				hit_q     <= 1'b0;
				slot_q    <= '0;
				evicted_q <= '0;
			end else if (hit_f_q) begin
				hit_q     <= 1'b1;
				slot_q    <= hit_idx_q;
				evicted_q <= '0;
			end else begin
				hit_q     <= 1'b0;
				slot_q    <= miss_idx;
				evicted_q <= emp_f_q ? '0 : best_page_q;
			end
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign evicted_page = evicted_q;
	assign fault_total  = fault_count_q;

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page frame policy with recency stamps.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) carries one page number. The block
// scans the active frames of its frame table one per cycle, comparing pages
// and tracking the first empty frame and the oldest stamp, then commits the
// hit, fill or replacement. done is registered from the commit state, which
// follows the scan of the single-port frame memory and a drain state.
// The next request is taken at the edge that ends the strobe cycle, so a
// request is never accepted while the one before it is still in flight.
// The result is valid only in the one cycle done is high and cannot be held
// off by the receiver. num_frames must be written only while the block is
// idle, which it does not enforce; 0 acts as 1, above MAX_FRAMES as MAX_FRAMES.
// ----------------------------------------------------------------------------
module lru_page_replacement
	import lru_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [PAGE_BITS-1:0]               page_number,
	input  logic                               num_frames_we,
	input  logic [CFG_W-1:0]                   num_frames,
	output logic                               done,
	output logic                               hit,
	output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] slot,
	output logic [PAGE_BITS-1:0]               evicted_page,
	output logic [FAULT_W-1:0]                 fault_total
);

	lru_cmd_t    cmd;
	lru_status_t status;

	lru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lru_dpath #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.page_number   (page_number),
		.num_frames_we (num_frames_we),
		.num_frames    (num_frames),
		.done          (done),
		.hit           (hit),
		.slot          (slot),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

endmodule

// ===== rtl/core/lru_checker.sv =====
// ----------------------------------------------------------------------------
// lru_checker
// Port-level checks on the request / result sequencing of the LRU block.
// ----------------------------------------------------------------------------
module lru_checker #(
	parameter int PAGE_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic                 hit,
	input logic [PAGE_BITS-1:0] evicted_page
);

	// an accepted request holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// the end of a request always delivers exactly one result
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result strobe");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a hit never removes a page
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (evicted_page == '0))
		else $error("hit reported an evicted page");

endmodule

bind lru_page_replacement lru_checker #(
	.PAGE_BITS (PAGE_BITS)
) u_lru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hit          (hit),
	.evicted_page (evicted_page)
);

// ===== verif/tb_lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page frame block. A queue of page requests
// and frame-count writes feeds a clocked driver; a shadow frame table with
// recency stamps predicts hit, slot, evicted page and fault total for every
// accepted request, and a clocked monitor checks each done strobe in order.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
	import lru_pkg::*;

	localparam int FRAMES      = 16;
	localparam int PAGE_W      = 16;
	localparam int SLOT_W      = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 11;
	localparam int PHASE_REQS  = 100;

	typedef struct {
		bit                 is_cfg;
		logic [PAGE_W-1:0]  page;
		logic [CFG_W-1:0]   frames;
		int                 hold;
	} lru_req_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [PAGE_W-1:0]  evicted;
		logic [FAULT_W-1:0] faults;
	} lru_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [PAGE_W-1:0]  page_number = '0;
	logic               num_frames_we = 1'b0;
	logic [CFG_W-1:0]   num_frames = '0;
	logic               done;
	logic               hit;
	logic [SLOT_W-1:0]  slot;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FAULT_W-1:0] fault_total;

	lru_req_t request_q[$];
	lru_res_t lookup_q[$];
	int       issued = 0;
	int       retired = 0;
	int       err_cnt = 0;
	int       idle_cycles = 0;
	int       gap = 0;

	// shadow frame table
	logic [PAGE_W-1:0]  shadow_page [FRAMES];
	logic [STAMP_W-1:0] shadow_stamp [FRAMES];
	logic [STAMP_W-1:0] shadow_next;
	logic [FAULT_W-1:0] shadow_faults;
	logic [CFG_W-1:0]   shadow_frames;

	logic [CFG_W-1:0]   phase_frames [PHASES];

	lru_page_replacement i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_number   (page_number),
		.num_frames_we (num_frames_we),
		.num_frames    (num_frames),
		.done          (done),
		.hit           (hit),
		.slot          (slot),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic lru_res_t lru_lookup(input logic [PAGE_W-1:0] page);
		lru_res_t           r;
		int                 n;
		int                 i;
		bit                 found;
		logic [STAMP_W-1:0] oldest;
		r = '0;
		found = 1'b0;
		n = (shadow_frames == 0) ? 1 : ((shadow_frames > FRAMES) ? FRAMES : shadow_frames);
		if (page != '0) begin
			for (i = 0; i < n && !found; i++) begin
				if (shadow_page[i] == page) begin
					r.slot = i[SLOT_W-1:0];
					r.hit = 1'b1;
					found = 1'b1;
				end
			end
			if (!found) begin
				for (i = 0; i < n && !found; i++) begin
					if (shadow_page[i] == '0) begin
						r.slot = i[SLOT_W-1:0];
						found = 1'b1;
					end
				end
				// all active frames full: replace the oldest stamp, lowest index on ties
				if (!found) begin
					oldest = shadow_stamp[0];
					r.slot = '0;
					for (i = 1; i < n; i++) begin
						if (shadow_stamp[i] < oldest) begin
							oldest = shadow_stamp[i];
							r.slot = i[SLOT_W-1:0];
						end
					end
					r.evicted = shadow_page[r.slot];
				end
				shadow_page[r.slot] = page;
				if (shadow_faults != FAULT_MAX)
					shadow_faults = shadow_faults + 1'b1;
			end
			shadow_stamp[r.slot] = shadow_next;
			if (shadow_next != STAMP_MAX)
				shadow_next = shadow_next + 1'b1;
		end
		r.faults = shadow_faults;
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 8);
		return $urandom_range(9, 40);
	endfunction

	task automatic push_page(input logic [PAGE_W-1:0] p, input bit burst);
		lru_req_t q;
		q.is_cfg = 1'b0;
		q.page = p;
		q.frames = '0;
		q.hold = burst ? 0 : draw_gap();
		request_q.push_back(q);
	endtask

	task automatic push_frames(input logic [CFG_W-1:0] v);
		lru_req_t q;
		q.is_cfg = 1'b1;
		q.page = '0;
		q.frames = v;
		q.hold = 0;
		request_q.push_back(q);
	endtask

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	// driver: one nonblocking write per signal per edge
	always @(posedge clk or negedge arst_n) begin : drv
		logic              nxt_start;
		logic              nxt_we;
		logic [PAGE_W-1:0] nxt_page;
		logic [CFG_W-1:0]  nxt_frames;
		int                nxt_gap;
		if (!arst_n) begin
			start <= 1'b0;
			page_number <= '0;
			num_frames_we <= 1'b0;
			num_frames <= '0;
			gap <= 0;
		end else begin
			nxt_start = start;
			nxt_we = 1'b0;
			nxt_page = page_number;
			nxt_frames = num_frames;
			nxt_gap = gap;
			if (start && !busy) begin
				lookup_q.push_back(lru_lookup(page_number));
				issued <= issued + 1;
				nxt_start = 1'b0;
				nxt_gap = (request_q.size() > 0) ? request_q[0].hold : 0;
			end
			if (!nxt_start) begin
				if (nxt_gap > 0) begin
					nxt_gap--;
				end else if (request_q.size() > 0) begin
					if (!request_q[0].is_cfg) begin
						nxt_start = 1'b1;
						nxt_page = request_q[0].page;
						void'(request_q.pop_front());
					end else if (!start && issued == retired) begin
						// block idle: write the frame count
						nxt_we = 1'b1;
						nxt_frames = request_q[0].frames;
						shadow_frames = request_q[0].frames;
						void'(request_q.pop_front());
					end
				end
			end
			start <= nxt_start;
			num_frames_we <= nxt_we;
			page_number <= nxt_page;
			num_frames <= nxt_frames;
			gap <= nxt_gap;
		end
	end

	always @(posedge clk) begin : mon
		lru_res_t want;
		if (arst_n && done) begin
			if (lookup_q.size() == 0) begin
				report("result strobe with no request pending");
			end else begin
				want = lookup_q.pop_front();
				retired <= retired + 1;
				if (hit !== want.hit)
					report($sformatf("hit got %0b want %0b", hit, want.hit));
				if (slot !== want.slot)
					report($sformatf("slot got %0d want %0d", slot, want.slot));
				if (evicted_page !== want.evicted)
					report($sformatf("evicted_page got %0h want %0h",
						evicted_page, want.evicted));
				if (fault_total !== want.faults)
					report($sformatf("fault_total got %0d want %0d",
						fault_total, want.faults));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main
		logic [PAGE_W-1:0] pool[$];
		int                k;
		int                j;
		int                n_eff;
		int                target;
		int                r;
		bit                burst;
		for (k = 0; k < FRAMES; k++) begin
			shadow_page[k] = '0;
			shadow_stamp[k] = '0;
		end
		shadow_next = '0;
		shadow_faults = '0;
		shadow_frames = CFG_RESET;
		phase_frames = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd9,
			5'd16, 5'd3, 5'd1};

		// directed: zero page, page extremes, hit, fill, replacement, clamped counts
		push_page(16'h0000, 1'b0);
		push_page(16'h0001, 1'b0);
		push_page(16'hFFFF, 1'b0);
		push_page(16'h0001, 1'b0);
		push_page(16'h8000, 1'b0);
		push_page(16'h0000, 1'b0);
		push_frames(5'd2);
		push_page(16'h0001, 1'b0);
		push_page(16'h0005, 1'b0);
		push_page(16'hFFFF, 1'b0);
		push_frames(5'd0);
		push_page(16'h0007, 1'b0);
		push_page(16'h0007, 1'b0);
		push_page(16'h0009, 1'b0);
		// widen again: frames left above the old count come back into the search
		push_frames(5'd31);
		push_page(16'h8000, 1'b0);
		push_page(16'h0005, 1'b0);
		push_page(16'h5555, 1'b0);
		push_page(16'hAAAA, 1'b0);
		push_page(16'h0000, 1'b0);

		// random phases: mostly reuse of a working set larger than the frames (it may carry over)
		for (k = 0; k < PHASES; k++) begin
			push_frames(phase_frames[k]);
			n_eff = (phase_frames[k] == 0) ? 1 :
				((phase_frames[k] > FRAMES) ? FRAMES : phase_frames[k]);
			burst = (k % 3 == 2);
			if ($urandom_range(0, 1))
				pool.delete();
			target = n_eff + $urandom_range(1, 4);
			while (pool.size() < target)
				pool.push_back(16'($urandom_range(1, 65535)));
			for (j = 0; j < PHASE_REQS; j++) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					push_page(pool[$urandom_range(0, pool.size() - 1)], burst);
				else if (r < 95)
					push_page(16'($urandom_range(1, 65535)), burst);
				else
					push_page(16'h0000, burst);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_q.size() != 0 || start || issued != retired)
			@(negedge clk);
		repeat (FRAMES + 3 + 8) @(posedge clk);
		if (lookup_q.size() != 0)
			report($sformatf("%0d results never arrived", lookup_q.size()));
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lru_pkg.sv
rtl/core/lru_ctrl.sv
rtl/core/lru_dpath.sv
rtl/core/lru_page_replacement.sv
rtl/core/lru_checker.sv
verif/tb_lru_page_replacement.sv
